// File: hdl/fbr_pkg.sv
package fbr_pkg;

    // parser states, numbered as seen on the result port
    typedef enum logic [4:0] {
        ST_HUNT    = 5'd0,
        ST_PRE2    = 5'd1,
        ST_DELIM   = 5'd2,
        ST_ADDR    = 5'd3,
        ST_UADDR   = 5'd4,
        ST_EXP1    = 5'd5,
        ST_EXPN    = 5'd6,
        ST_CMD     = 5'd7,
        ST_LEN     = 5'd8,
        ST_RSP1    = 5'd9,
        ST_RSP2    = 5'd10,
        ST_PAY1    = 5'd11,
        ST_PAYN    = 5'd12,
        ST_CHK     = 5'd13,
        ST_GARB0   = 5'd14,
        ST_GARB    = 5'd15,
        ST_DONE    = 5'd16,
        ST_INVALID = 5'd17,
        ST_CHKERR  = 5'd18
    } t_parse_state;

    // field just consumed
    typedef enum logic [3:0] {
        FK_NONE      = 4'd0,
        FK_DELIM     = 4'd1,
        FK_ADDRESS   = 4'd2,
        FK_EXPANSION = 4'd3,
        FK_COMMAND   = 4'd4,
        FK_COUNT     = 4'd5,
        FK_RESP1     = 4'd6,
        FK_RESP2     = 4'd7,
        FK_PAYLOAD   = 4'd8,
        FK_CHECKSUM  = 4'd9
    } t_field_kind;

    // frame classification
    typedef enum logic [2:0] {
        FT_UNKNOWN  = 3'd0,
        FT_REQUEST  = 3'd1,
        FT_RESPONSE = 3'd2,
        FT_BURST    = 3'd3,
        FT_JUNK     = 3'd4
    } t_frame_type;

    // input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_GAP   = 2'd1;
    localparam logic [1:0] CMD_REARM = 2'd2;

    // configuration register indexes
    localparam logic CFG_SKIP_PREAMBLE = 1'b0;
    localparam logic CFG_MAX_PREAMBLES = 1'b1;

    // delimiter frame codes (low three bits)
    localparam logic [2:0] DELIM_BACK = 3'd1;
    localparam logic [2:0] DELIM_STX  = 3'd2;
    localparam logic [2:0] DELIM_ACK  = 3'd6;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam logic [7:0] ADDR_MASK     = 8'h3F;
    localparam logic [7:0] MAX_PRE_RESET = 8'd20;

    typedef struct packed {
        logic       skip_preamble;
        logic [7:0] max_preambles;
    } t_cfg;

    typedef struct packed {
        t_parse_state parser_state;
        logic [2:0]   delimiter_code;
        logic [1:0]   expansion_total;
        logic [7:0]   field_counter;
        logic [7:0]   running_xor;
        logic         addressing_long;
        logic         master_bit;
        logic         burst_bit;
        logic [7:0]   announced_length;
        logic [7:0]   preambles_seen;
        logic [15:0]  bytes_received;
        t_frame_type  kind_of_frame;
    } t_frame_state;

    localparam t_frame_state FRAME_CLEAR = '{
        parser_state:     ST_HUNT,
        delimiter_code:   3'd0,
        expansion_total:  2'd0,
        field_counter:    8'd0,
        running_xor:      8'd0,
        addressing_long:  1'b0,
        master_bit:       1'b0,
        burst_bit:        1'b0,
        announced_length: 8'd0,
        preambles_seen:   8'd0,
        bytes_received:   16'd0,
        kind_of_frame:    FT_UNKNOWN
    };

    typedef struct packed {
        t_parse_state parse_state;
        t_field_kind  field_kind;
        logic [7:0]   field_index;
        logic [7:0]   field_value;
        logic         frame_end;
        t_frame_type  frame_type;
        logic         long_address;
        logic         primary_master;
        logic         burst_flag;
        logic [7:0]   payload_length;
        logic [7:0]   preamble_count;
        logic [15:0]  received_count;
    } t_result;

endpackage

// File: hdl/fbr_step.sv
module fbr_step #(
    parameter int UNIQUE_ADDR_BYTES = 5
) (
    input  fbr_pkg::t_frame_state i_state,
    input  fbr_pkg::t_cfg         i_cfg,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_line_error,
    output fbr_pkg::t_frame_state o_state,
    output fbr_pkg::t_result      o_result
);

    localparam logic [7:0] UADDR_LAST = 8'(UNIQUE_ADDR_BYTES);

    logic [8:0]           pre_next;
    logic [2:0]           delim_low;
    logic                 delim_ok;
    logic [7:0]           cnt_inc;
    logic                 cur_terminal;
    fbr_pkg::t_frame_state nxt;
    fbr_pkg::t_field_kind  f_kind;
    logic [7:0]           f_index;
    logic [7:0]           f_value;
    logic                 nxt_terminal;

    // shared decode of a possible delimiter or further preamble
    assign pre_next  = {1'b0, i_state.preambles_seen} + 9'd1;
    assign delim_low = i_rx_byte[2:0];
    assign delim_ok  = (delim_low == fbr_pkg::DELIM_ACK) || (delim_low == fbr_pkg::DELIM_STX)
                    || (delim_low == fbr_pkg::DELIM_BACK);
    assign cnt_inc   = i_state.field_counter + 8'd1;
    assign cur_terminal = (i_state.parser_state == fbr_pkg::ST_DONE)
                       || (i_state.parser_state == fbr_pkg::ST_INVALID)
                       || (i_state.parser_state == fbr_pkg::ST_CHKERR);

    // one pass of the frame parser
    always_comb begin
        nxt     = i_state;
        f_kind  = fbr_pkg::FK_NONE;
        f_index = 8'd0;
        f_value = 8'd0;

        case (i_cmd)
            fbr_pkg::CMD_BYTE: begin
                unique case (i_state.parser_state)
                    fbr_pkg::ST_HUNT, fbr_pkg::ST_DELIM: begin
                        if (i_state.parser_state == fbr_pkg::ST_HUNT && !i_cfg.skip_preamble) begin
                            if (i_rx_byte == fbr_pkg::PREAMBLE_BYTE) begin
                                nxt.preambles_seen = 8'd1;
                                nxt.parser_state   = fbr_pkg::ST_PRE2;
                            end else begin
                                nxt.parser_state = fbr_pkg::ST_HUNT;
                            end
                        end else if (i_rx_byte == fbr_pkg::PREAMBLE_BYTE) begin
                            // further preamble, count saturates
                            nxt.preambles_seen = pre_next[8] ? 8'hFF : pre_next[7:0];
                            nxt.parser_state   = (pre_next > {1'b0, i_cfg.max_preambles})
                                               ? fbr_pkg::ST_GARB0 : fbr_pkg::ST_DELIM;
                        end else if (delim_ok) begin
                            nxt.expansion_total = i_rx_byte[6:5];
                            nxt.delimiter_code  = delim_low;
                            nxt.running_xor     = i_rx_byte;
                            nxt.addressing_long = i_rx_byte[7];
                            f_kind              = fbr_pkg::FK_DELIM;
                            f_value             = i_rx_byte;
                            nxt.parser_state    = fbr_pkg::ST_ADDR;
                        end else begin
                            nxt.parser_state = fbr_pkg::ST_HUNT;
                        end
                    end
                    fbr_pkg::ST_PRE2: begin
                        if (i_rx_byte == fbr_pkg::PREAMBLE_BYTE) begin
                            nxt.preambles_seen = 8'd2;
                            nxt.parser_state   = fbr_pkg::ST_DELIM;
                        end else begin
                            nxt.parser_state = fbr_pkg::ST_HUNT;
                        end
                    end
                    fbr_pkg::ST_ADDR: begin
                        nxt.running_xor   = i_state.running_xor ^ i_rx_byte;
                        nxt.master_bit    = i_rx_byte[7];
                        nxt.burst_bit     = i_rx_byte[6];
                        nxt.field_counter = 8'd1;
                        f_kind            = fbr_pkg::FK_ADDRESS;
                        f_value           = i_rx_byte & fbr_pkg::ADDR_MASK;
                        if (i_state.addressing_long) begin
                            nxt.parser_state = fbr_pkg::ST_UADDR;
                        end else begin
                            nxt.parser_state = (i_state.expansion_total != 2'd0)
                                             ? fbr_pkg::ST_EXP1 : fbr_pkg::ST_CMD;
                        end
                    end
                    fbr_pkg::ST_UADDR: begin
                        nxt.running_xor   = i_state.running_xor ^ i_rx_byte;
                        nxt.field_counter = cnt_inc;
                        f_kind            = fbr_pkg::FK_ADDRESS;
                        f_index           = i_state.field_counter;
                        f_value           = i_rx_byte;
                        if (cnt_inc >= UADDR_LAST) begin
                            nxt.parser_state = (i_state.expansion_total != 2'd0)
                                             ? fbr_pkg::ST_EXP1 : fbr_pkg::ST_CMD;
                        end else begin
                            nxt.parser_state = fbr_pkg::ST_UADDR;
                        end
                    end
                    fbr_pkg::ST_EXP1: begin
                        nxt.running_xor   = i_state.running_xor ^ i_rx_byte;
                        nxt.field_counter = 8'd1;
                        f_kind            = fbr_pkg::FK_EXPANSION;
                        f_value           = i_rx_byte;
                        nxt.parser_state  = (i_state.expansion_total <= 2'd1)
                                          ? fbr_pkg::ST_CMD : fbr_pkg::ST_EXPN;
                    end
                    fbr_pkg::ST_EXPN: begin
                        nxt.running_xor   = i_state.running_xor ^ i_rx_byte;
                        nxt.field_counter = cnt_inc;
                        f_kind            = fbr_pkg::FK_EXPANSION;
                        f_index           = i_state.field_counter;
                        f_value           = i_rx_byte;
                        nxt.parser_state  = (cnt_inc >= {6'd0, i_state.expansion_total})
                                          ? fbr_pkg::ST_CMD : fbr_pkg::ST_EXPN;
                    end
                    fbr_pkg::ST_CMD: begin
                        nxt.running_xor  = i_state.running_xor ^ i_rx_byte;
                        f_kind           = fbr_pkg::FK_COMMAND;
                        f_value          = i_rx_byte;
                        nxt.parser_state = fbr_pkg::ST_LEN;
                    end
                    fbr_pkg::ST_LEN: begin
                        nxt.running_xor = i_state.running_xor ^ i_rx_byte;
                        f_kind          = fbr_pkg::FK_COUNT;
                        f_value         = i_rx_byte;
                        if (i_state.delimiter_code == fbr_pkg::DELIM_STX) begin
                            nxt.announced_length = i_rx_byte;
                            nxt.parser_state     = (i_rx_byte != 8'd0)
                                                 ? fbr_pkg::ST_PAY1 : fbr_pkg::ST_CHK;
                        end else if (i_rx_byte >= 8'd2) begin
                            // replies carry two response bytes ahead of the payload
                            nxt.announced_length = i_rx_byte - 8'd2;
                            nxt.parser_state     = fbr_pkg::ST_RSP1;
                        end else begin
                            nxt.parser_state = fbr_pkg::ST_INVALID;
                        end
                    end
                    fbr_pkg::ST_RSP1: begin
                        nxt.running_xor  = i_state.running_xor ^ i_rx_byte;
                        f_kind           = fbr_pkg::FK_RESP1;
                        f_value          = i_rx_byte;
                        nxt.parser_state = fbr_pkg::ST_RSP2;
                    end
                    fbr_pkg::ST_RSP2: begin
                        nxt.running_xor  = i_state.running_xor ^ i_rx_byte;
                        f_kind           = fbr_pkg::FK_RESP2;
                        f_value          = i_rx_byte;
                        nxt.parser_state = (i_state.announced_length != 8'd0)
                                         ? fbr_pkg::ST_PAY1 : fbr_pkg::ST_CHK;
                    end
                    fbr_pkg::ST_PAY1: begin
                        nxt.running_xor   = i_state.running_xor ^ i_rx_byte;
                        nxt.field_counter = 8'd1;
                        f_kind            = fbr_pkg::FK_PAYLOAD;
                        f_value           = i_rx_byte;
                        nxt.parser_state  = (i_state.announced_length == 8'd1)
                                          ? fbr_pkg::ST_CHK : fbr_pkg::ST_PAYN;
                    end
                    fbr_pkg::ST_PAYN: begin
                        nxt.running_xor   = i_state.running_xor ^ i_rx_byte;
                        nxt.field_counter = cnt_inc;
                        f_kind            = fbr_pkg::FK_PAYLOAD;
                        f_index           = i_state.field_counter;
                        f_value           = i_rx_byte;
                        nxt.parser_state  = (cnt_inc >= i_state.announced_length)
                                          ? fbr_pkg::ST_CHK : fbr_pkg::ST_PAYN;
                    end
                    fbr_pkg::ST_CHK: begin
                        f_kind           = fbr_pkg::FK_CHECKSUM;
                        f_value          = i_rx_byte;
                        nxt.parser_state = (i_rx_byte == i_state.running_xor)
                                         ? fbr_pkg::ST_DONE : fbr_pkg::ST_CHKERR;
                    end
                    fbr_pkg::ST_GARB0, fbr_pkg::ST_GARB: begin
                        nxt.parser_state = fbr_pkg::ST_GARB;
                    end
                    default: begin
                        nxt.parser_state = i_state.parser_state;
                    end
                endcase

                // a flagged byte is decoded, then discarded as garbage
                if (i_line_error) begin
                    nxt.parser_state = fbr_pkg::ST_GARB0;
                    f_kind           = fbr_pkg::FK_NONE;
                    f_index          = 8'd0;
                    f_value          = 8'd0;
                end
                nxt.bytes_received = i_state.bytes_received + 16'd1;
            end
            fbr_pkg::CMD_GAP: begin
                if (!cur_terminal && (i_state.parser_state != fbr_pkg::ST_HUNT
                                      || i_state.bytes_received != 16'd0)) begin
                    nxt.parser_state = fbr_pkg::ST_INVALID;
                end
            end
            fbr_pkg::CMD_REARM: begin
                nxt = fbr_pkg::FRAME_CLEAR;
            end
            default: begin
                nxt = i_state;
            end
        endcase

        // classify the frame once it ends
        if (nxt.parser_state == fbr_pkg::ST_DONE) begin
            case (nxt.delimiter_code)
                fbr_pkg::DELIM_STX:  nxt.kind_of_frame = fbr_pkg::FT_REQUEST;
                fbr_pkg::DELIM_ACK:  nxt.kind_of_frame = fbr_pkg::FT_RESPONSE;
                fbr_pkg::DELIM_BACK: nxt.kind_of_frame = fbr_pkg::FT_BURST;
                default:             nxt.kind_of_frame = fbr_pkg::FT_JUNK;
            endcase
        end else if (nxt.parser_state == fbr_pkg::ST_INVALID
                     || nxt.parser_state == fbr_pkg::ST_CHKERR) begin
            nxt.kind_of_frame = fbr_pkg::FT_JUNK;
        end
    end

    assign nxt_terminal = (nxt.parser_state == fbr_pkg::ST_DONE)
                       || (nxt.parser_state == fbr_pkg::ST_INVALID)
                       || (nxt.parser_state == fbr_pkg::ST_CHKERR);

    assign o_state = nxt;

    // result fields from the updated state
    assign o_result.parse_state    = nxt.parser_state;
    assign o_result.field_kind     = f_kind;
    assign o_result.field_index    = f_index;
    assign o_result.field_value    = f_value;
    assign o_result.frame_end      = nxt_terminal;
    assign o_result.frame_type     = nxt.kind_of_frame;
    assign o_result.long_address   = nxt.addressing_long;
    assign o_result.primary_master = nxt.master_bit;
    assign o_result.burst_flag     = nxt.burst_bit;
    assign o_result.payload_length = nxt.announced_length;
    assign o_result.preamble_count = nxt.preambles_seen;
    assign o_result.received_count = nxt.bytes_received;

endmodule

// File: hdl/field_bus_frame_receiver.sv
// Byte-serial receiver for field bus frames with at least two 0xFF preambles (optional
// when skip_preamble is set), a delimiter, short or long address, up to three expansion
// bytes, command, byte count, optional response bytes, streamed payload and an XOR
// checksum. Each input transfer carries one command (received byte, gap timeout or
// rearm) and yields exactly one result transfer with the parser state after that
// command and the field just consumed. One transfer is taken every clock cycle while
// the input side is not stalled; a transfer goes through an input register and the result
// register, with the combinational state update between them. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module field_bus_frame_receiver #(
    parameter int UNIQUE_ADDR_BYTES = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_line_error,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_parse_state,
    output logic [3:0]  o_field_kind,
    output logic [7:0]  o_field_index,
    output logic [7:0]  o_field_value,
    output logic        o_frame_end,
    output logic [2:0]  o_frame_type,
    output logic        o_long_address,
    output logic        o_primary_master,
    output logic        o_burst_flag,
    output logic [7:0]  o_payload_length,
    output logic [7:0]  o_preamble_count,
    output logic [15:0] o_received_count
);

    fbr_pkg::t_cfg         r_cfg;
    fbr_pkg::t_frame_state r_state;
    fbr_pkg::t_frame_state n_state;
    fbr_pkg::t_result      n_res;
    fbr_pkg::t_result      r_res;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic [1:0]            r_cmd;
    logic [7:0]            r_rx_byte;
    logic                  r_line_error;
    logic                  in_xfer;
    logic                  advance;

    // stage moves when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.skip_preamble <= 1'b0;
            r_cfg.max_preambles <= fbr_pkg::MAX_PRE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fbr_pkg::CFG_SKIP_PREAMBLE) begin
                r_cfg.skip_preamble <= i_cfg_data[0];
            end else begin
                r_cfg.max_preambles <= i_cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd        <= i_cmd;
            r_rx_byte    <= i_rx_byte;
            r_line_error <= i_line_error;
        end
    end

    fbr_step #(
        .UNIQUE_ADDR_BYTES(UNIQUE_ADDR_BYTES)
    ) u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_cmd        (r_cmd),
        .i_rx_byte    (r_rx_byte),
        .i_line_error (r_line_error),
        .o_state      (n_state),
        .o_result     (n_res)
    );

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbr_pkg::FRAME_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parse_state    = r_res.parse_state;
    assign o_field_kind     = r_res.field_kind;
    assign o_field_index    = r_res.field_index;
    assign o_field_value    = r_res.field_value;
    assign o_frame_end      = r_res.frame_end;
    assign o_frame_type     = r_res.frame_type;
    assign o_long_address   = r_res.long_address;
    assign o_primary_master = r_res.primary_master;
    assign o_burst_flag     = r_res.burst_flag;
    assign o_payload_length = r_res.payload_length;
    assign o_preamble_count = r_res.preamble_count;
    assign o_received_count = r_res.received_count;

endmodule

// File: hdl/fbr_checker.sv
module fbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [4:0]  o_parse_state,
    input logic [3:0]  o_field_kind,
    input logic        o_frame_end,
    input logic [15:0] o_received_count
);

    // a stalled result stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_parse_state)
            && $stable(o_received_count))
        else $error("stalled result changed");

    // input side only backs up behind a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // frame end flag agrees with the terminal states
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_end == (o_parse_state == fbr_pkg::ST_DONE
            || o_parse_state == fbr_pkg::ST_INVALID || o_parse_state == fbr_pkg::ST_CHKERR)))
        else $error("frame end flag disagrees with state");

    // a checksum byte always closes the frame
    a_chk_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_kind == fbr_pkg::FK_CHECKSUM
            |-> o_parse_state == fbr_pkg::ST_DONE || o_parse_state == fbr_pkg::ST_CHKERR)
        else $error("checksum field without frame end");

endmodule

bind field_bus_frame_receiver fbr_checker u_fbr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_parse_state    (o_parse_state),
    .o_field_kind     (o_field_kind),
    .o_frame_end      (o_frame_end),
    .o_received_count (o_received_count)
);
